### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TFHR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define TFHR_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`endif

### rtl/tfhr_pkg.sv
// shared types and constants of the timestamped frame history ring
package tfhr_pkg;

    localparam int CAPACITY_DEF    = 4096;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF  = 48;

    localparam int FUNC_W = 2;
    localparam int LEN_W  = 13;
    localparam int OFF_W  = 12;
    localparam int WORD_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

### rtl/tfhr_ram.sv
// generic single port ram with registered read
module tfhr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/timestamped_frame_history_ring_core.sv
// top level of the timestamped frame history ring
//
//  channel   valid        ready        payload
//  input     i_in_valid   o_in_ready   i_func, i_sample_index, i_window_length,
//                                      i_frame_offset, i_sample_left, i_sample_right
//  output    o_out_valid  i_out_ready  o_ok, o_data_left, o_data_right, o_last_frame,
//                                      o_oldest_sample, o_newest_end
//
// one word at a time: push, clear and no-op pass the execute step to the result
// register, a read adds the address check, then the frame store read port
// the next word is accepted once the result is in the output register, even if
// it has not been taken yet; a stalled output holds the last step in place
// reset clears the timeline, the control state and the output valid; the frame store keeps its contents
module timestamped_frame_history_ring_core import tfhr_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [INDEX_BITS-1:0] i_sample_index,
    input  logic [LEN_W-1:0]      i_window_length,
    input  logic [OFF_W-1:0]      i_frame_offset,
    input  logic [WORD_W-1:0]     i_sample_left,
    input  logic [WORD_W-1:0]     i_sample_right,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [WORD_W-1:0]     o_data_left,
    output logic [WORD_W-1:0]     o_data_right,
    output logic                  o_last_frame,
    output logic [INDEX_BITS-1:0] o_oldest_sample,
    output logic [INDEX_BITS-1:0] o_newest_end
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int AW     = ((FILL_W > OFF_W) ? FILL_W : OFF_W) + 3;
    localparam int RAM_W  = 2 * SAMPLE_BITS;

    t_state r_state, n_state;

    // captured word
    t_func                  r_func;
    logic [INDEX_BITS-1:0]  r_idx;
    logic [LEN_W-1:0]       r_len;
    logic [OFF_W-1:0]       r_off;
    logic [SAMPLE_BITS-1:0] r_left;
    logic [SAMPLE_BITS-1:0] r_right;

    // timeline
    logic                  r_tl_valid;
    logic [INDEX_BITS-1:0] r_tl_start;
    logic [INDEX_BITS-1:0] r_tl_end;
    logic [FILL_W-1:0]     r_fill;
    logic [SLOT_W-1:0]     r_wslot;

    // read check and result staging
    logic [INDEX_BITS-1:0] r_d;
    logic                  r_res_ok;
    logic                  r_res_last;
    logic                  r_res_ram;

    // output register
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [WORD_W-1:0]     r_out_left;
    logic [WORD_W-1:0]     r_out_right;
    logic                  r_out_last;
    logic [INDEX_BITS-1:0] r_out_oldest;
    logic [INDEX_BITS-1:0] r_out_newest;

    logic                  accept_in;
    logic                  out_free;
    logic                  restart;
    logic                  full;
    logic [SLOT_W-1:0]     push_slot;
    logic [INDEX_BITS-1:0] push_base;
    logic                  basic_ok;
    logic                  d_le;
    logic [FILL_W-1:0]     d_low;
    logic [CMP_W-1:0]      room;
    logic                  fits;
    logic [AW-1:0]         raw_addr;
    logic [AW-1:0]         fix_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [SLOT_W-1:0]     ram_addr;
    logic [RAM_W-1:0]      ram_rdata;

    assign accept_in = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // push: continue the timeline or restart it
    assign restart   = !r_tl_valid || (r_idx != r_tl_end);
    assign full      = (r_fill == FILL_W'(CAPACITY));
    assign push_slot = restart ? '0 : r_wslot;
    assign push_base = restart ? r_idx : r_tl_end;

    // read: window must lie inside the stored span
    assign basic_ok = r_tl_valid && (r_len != '0) && (LEN_W'(r_off) < r_len);
    assign d_le     = (r_d <= INDEX_BITS'(r_fill));
    assign d_low    = r_d[FILL_W-1:0];
    assign room     = CMP_W'(r_fill) - CMP_W'(d_low);
    assign fits     = basic_ok && d_le && (CMP_W'(r_len) <= room);
    assign raw_addr = AW'(r_wslot) + AW'(d_low) + AW'(r_off) - AW'(r_fill);
    assign fix_addr = raw_addr[AW-1] ? (raw_addr + AW'(CAPACITY)) : raw_addr;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_func == FUNC_READ) ? S_CHECK : S_DONE;
            end
            S_CHECK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = fix_addr[SLOT_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                ram_we   = (r_func == FUNC_PUSH);
                ram_addr = push_slot;
            end
            S_CHECK: begin
                ram_re = fits;
            end
            S_DONE: begin
                ram_re = 1'b0;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_func  <= t_func'(i_func);
            r_idx   <= i_sample_index;
            r_len   <= i_window_length;
            r_off   <= i_frame_offset;
            r_left  <= i_sample_left[SAMPLE_BITS-1:0];
            r_right <= i_sample_right[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl_valid <= 1'b0;
            r_tl_start <= '0;
            r_tl_end   <= '0;
            r_fill     <= '0;
            r_wslot    <= '0;
        end else if (r_state == S_EXEC) begin
            case (r_func)
                FUNC_PUSH: begin
                    r_tl_valid <= 1'b1;
                    if (restart) begin
                        r_tl_start <= r_idx;
                        r_fill     <= FILL_W'(1);
                    end else if (full) begin
                        r_tl_start <= r_tl_start + INDEX_BITS'(1);
                    end else begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_tl_end <= push_base + INDEX_BITS'(1);
                    r_wslot  <= (push_slot == SLOT_W'(CAPACITY - 1)) ? '0
                                : push_slot + SLOT_W'(1);
                end
                FUNC_CLEAR: begin
                    r_tl_valid <= 1'b0;
                    r_tl_start <= '0;
                    r_tl_end   <= '0;
                    r_fill     <= '0;
                    r_wslot    <= '0;
                end
                default: begin
                    r_tl_valid <= r_tl_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_d        <= r_idx - r_tl_start;
            r_res_ok   <= (r_func == FUNC_PUSH) || (r_func == FUNC_CLEAR);
            r_res_last <= 1'b0;
            r_res_ram  <= 1'b0;
        end else if (r_state == S_CHECK) begin
            r_res_ok   <= fits;
            r_res_last <= fits && (LEN_W'(r_off) == (r_len - LEN_W'(1)));
            r_res_ram  <= fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_ok     <= r_res_ok;
            r_out_last   <= r_res_last;
            r_out_left   <= r_res_ram ? WORD_W'(ram_rdata[SAMPLE_BITS-1:0]) : '0;
            r_out_right  <= r_res_ram ? WORD_W'(ram_rdata[RAM_W-1:SAMPLE_BITS]) : '0;
            r_out_oldest <= r_tl_valid ? r_tl_start : '0;
            r_out_newest <= r_tl_valid ? r_tl_end : '0;
        end
    end

    tfhr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata ({r_right, r_left}),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_data_left     = r_out_left;
    assign o_data_right    = r_out_right;
    assign o_last_frame    = r_out_last;
    assign o_oldest_sample = r_out_oldest;
    assign o_newest_end    = r_out_newest;

endmodule

### rtl/tfhr_checker.sv
// port level checks of the frame history ring, bound to the top level
`include "assert_macros.svh"

module tfhr_checker import tfhr_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_ok,
    input logic [WORD_W-1:0]     o_data_left,
    input logic [WORD_W-1:0]     o_data_right,
    input logic                  o_last_frame,
    input logic [INDEX_BITS-1:0] o_oldest_sample,
    input logic [INDEX_BITS-1:0] o_newest_end
);

    logic                           stalled;
    logic [2*WORD_W+2*INDEX_BITS:0] out_word;
    logic                           out_data_zero;

    assign stalled       = o_out_valid && !i_out_ready;
    assign out_word      = {o_ok, o_data_left, o_data_right, o_oldest_sample, o_newest_end};
    assign out_data_zero = ({o_data_left, o_data_right} == '0);

    // stalled result word holds
    `TFHR_ASSERT(a_out_hold, i_clk, i_rst_n, stalled |=> (o_out_valid && $stable(out_word)))

    // one word in flight: no accept right after an accept
    `TFHR_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)

    // words that are not ok (failed reads, no-ops) return no data
    `TFHR_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_out_valid && !o_ok) |-> out_data_zero)

    // last frame flag only on a good read
    `TFHR_NEVER(a_last_needs_ok, i_clk, i_rst_n, o_out_valid && o_last_frame && !o_ok)

endmodule

bind timestamped_frame_history_ring_core tfhr_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_tfhr_checker (.*);

### test/tb_timestamped_frame_history_ring_core.sv
// self-checking testbench for the timestamped frame history ring: directed and random words
module tb_timestamped_frame_history_ring_core;
    import tfhr_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int IW         = INDEX_BITS_DEF;
    localparam int STALL_MAX  = 3000;
    localparam int PRINT_MAX  = 40;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic              last;
        logic [IW-1:0]     oldest;
        logic [IW-1:0]     newest;
    } t_ring_reply;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [FUNC_W-1:0] func = FUNC_NOP;
    logic [IW-1:0]     sample_index = '0;
    logic [LEN_W-1:0]  window_length = '0;
    logic [OFF_W-1:0]  frame_offset = '0;
    logic [WORD_W-1:0] sample_left = '0;
    logic [WORD_W-1:0] sample_right = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              ok;
    logic [WORD_W-1:0] data_left;
    logic [WORD_W-1:0] data_right;
    logic              last_frame;
    logic [IW-1:0]     oldest_sample;
    logic [IW-1:0]     newest_end;

    // expected ring contents and timeline
    logic [2*WORD_W-1:0] frame_copy [CAP];
    int unsigned         wr_slot = 0;
    int unsigned         fill = 0;
    logic [IW-1:0]       tl_start = '0;
    logic                tl_valid = 1'b0;

    t_ring_reply pending_replies [$];
    int          mismatch_count = 0;
    int          long_hold_cycles = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;

    timestamped_frame_history_ring_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_func          (func),
        .i_sample_index  (sample_index),
        .i_window_length (window_length),
        .i_frame_offset  (frame_offset),
        .i_sample_left   (sample_left),
        .i_sample_right  (sample_right),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_ok            (ok),
        .o_data_left     (data_left),
        .o_data_right    (data_right),
        .o_last_frame    (last_frame),
        .o_oldest_sample (oldest_sample),
        .o_newest_end    (newest_end)
    );

    initial forever #6 clk = ~clk;

    function automatic logic [IW-1:0] rand_index();
        return IW'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(99, 0);
        if (!enabled || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [IW-1:0] newest_end_now();
        logic [IW-1:0] s;
        s = tl_start + fill;
        return tl_valid ? s : '0;
    endfunction

    task automatic empty_timeline();
        wr_slot  = 0;
        fill     = 0;
        tl_start = '0;
        tl_valid = 1'b0;
    endtask

    task automatic predict_ring_reply(t_func f, logic [IW-1:0] idx, logic [LEN_W-1:0] len,
                                      logic [OFF_W-1:0] off, logic [WORD_W-1:0] l,
                                      logic [WORD_W-1:0] r);
        t_ring_reply   rep;
        logic [IW-1:0] lead;
        int unsigned   slot;
        rep = '0;
        case (f)
            FUNC_PUSH: begin
                if (!tl_valid || idx != newest_end_now()) begin
                    empty_timeline();
                    tl_start = idx;
                    tl_valid = 1'b1;
                end
                if (fill >= CAP) begin
                    tl_start = tl_start + 1'b1;
                    fill     = CAP - 1;
                end
                frame_copy[wr_slot] = {l, r};
                wr_slot = (wr_slot + 1) % CAP;
                fill++;
                rep.ok = 1'b1;
            end
            FUNC_READ: begin
                if (tl_valid && len != 0 && off < len) begin
                    lead = idx - tl_start;
                    if (lead <= fill && len <= fill - lead) begin
                        slot = (wr_slot + CAP - fill + int'(lead) + off) % CAP;
                        rep.left  = frame_copy[slot][2*WORD_W-1:WORD_W];
                        rep.right = frame_copy[slot][WORD_W-1:0];
                        rep.ok    = 1'b1;
                        rep.last  = (off == len - 1);
                    end
                end
            end
            FUNC_CLEAR: begin
                empty_timeline();
                rep.ok = 1'b1;
            end
            default: ;
        endcase
        rep.oldest = tl_valid ? tl_start : '0;
        rep.newest = newest_end_now();
        pending_replies.push_back(rep);
    endtask

    // valid stays high after an accept; a gap or an idle wait lowers it
    task automatic send_word(t_func f, logic [IW-1:0] idx, logic [LEN_W-1:0] len,
                             logic [OFF_W-1:0] off, logic [WORD_W-1:0] l,
                             logic [WORD_W-1:0] r);
        int n;
        n = pick_gap(tx_gaps_on);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        sample_index  <= idx;
        window_length <= len;
        frame_offset  <= off;
        sample_left   <= l;
        sample_right  <= r;
        do @(posedge clk); while (!in_ready);
        predict_ring_reply(f, idx, len, off, l, r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic send_span_read();
        int unsigned lead;
        int unsigned len;
        int unsigned off;
        lead = $urandom_range(fill - 1, 0);
        len  = $urandom_range(fill - lead, 1);
        if ($urandom_range(1, 0) == 0 && len > 16) len = $urandom_range(16, 1);
        off  = $urandom_range(len - 1, 0);
        send_word(FUNC_READ, tl_start + lead, LEN_W'(len), OFF_W'(off), $urandom, $urandom);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
            $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task automatic check_reply();
        t_ring_reply want;
        if (pending_replies.size() == 0) begin
            report_mismatch("word with nothing expected", {63'd0, ok}, 64'd0);
            return;
        end
        want = pending_replies.pop_front();
        if (ok !== want.ok) report_mismatch("ok", 64'(ok), 64'(want.ok));
        if (data_left !== want.left)
            report_mismatch("data_left", 64'(data_left), 64'(want.left));
        if (data_right !== want.right)
            report_mismatch("data_right", 64'(data_right), 64'(want.right));
        if (last_frame !== want.last)
            report_mismatch("last_frame", 64'(last_frame), 64'(want.last));
        if (oldest_sample !== want.oldest)
            report_mismatch("oldest_sample", 64'(oldest_sample), 64'(want.oldest));
        if (newest_end !== want.newest)
            report_mismatch("newest_end", 64'(newest_end), 64'(want.newest));
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) check_reply();
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left == 0 && long_hold_cycles != 0) begin
                stall_left       = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(rx_gaps_on);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_MAX) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic test_empty_ring();
        send_word(FUNC_READ, '0, 13'd1, 12'd0, '0, '0);
        send_word(FUNC_NOP, '1, 13'd4096, '1, '1, '1);
        send_word(FUNC_CLEAR, '0, '0, '0, '0, '0);
    endtask

    task automatic test_push_and_read_edges();
        send_word(FUNC_PUSH, IW'(0), '0, '0, 32'h0000_0000, 32'h0000_0000);
        send_word(FUNC_PUSH, IW'(1), '0, '0, 32'hffff_ffff, 32'hffff_ffff);
        send_word(FUNC_PUSH, IW'(2), '0, '0, 32'haaaa_aaaa, 32'h5555_5555);
        send_word(FUNC_READ, IW'(0), 13'd3, 12'd0, '0, '0);
        send_word(FUNC_READ, IW'(0), 13'd3, 12'd2, '0, '0);
        send_word(FUNC_READ, IW'(1), 13'd2, 12'd1, '0, '0);
        // offset equal to length, zero length, window past newest, start before oldest
        send_word(FUNC_READ, IW'(0), 13'd3, 12'd3, '0, '0);
        send_word(FUNC_READ, IW'(0), 13'd0, 12'd0, '0, '0);
        send_word(FUNC_READ, IW'(0), 13'd4, 12'd0, '0, '0);
        send_word(FUNC_READ, '1, 13'd2, 12'd0, '0, '0);
        send_word(FUNC_READ, IW'(0), 13'd4096, 12'd4095, '0, '0);
        // index jump restarts the timeline
        send_word(FUNC_PUSH, IW'(1000), '0, '0, 32'h1234_5678, 32'h9abc_def0);
        send_word(FUNC_READ, IW'(0), 13'd1, 12'd0, '0, '0);
        send_word(FUNC_READ, IW'(1000), 13'd1, 12'd0, '0, '0);
    endtask

    task automatic test_index_wrap();
        logic [IW-1:0] top;
        top = '1;
        send_word(FUNC_PUSH, top - 1'b1, '0, '0, $urandom, $urandom);
        send_word(FUNC_PUSH, top, '0, '0, $urandom, $urandom);
        send_word(FUNC_PUSH, IW'(0), '0, '0, $urandom, $urandom);
        send_word(FUNC_PUSH, IW'(1), '0, '0, $urandom, $urandom);
        send_word(FUNC_READ, top - 1'b1, 13'd4, 12'd3, '0, '0);
        send_word(FUNC_READ, top, 13'd2, 12'd1, '0, '0);
        send_word(FUNC_CLEAR, '1, '1, '1, '1, '1);
        send_word(FUNC_READ, IW'(0), 13'd1, 12'd0, '0, '0);
    endtask

    task automatic test_full_ring();
        logic [IW-1:0] base;
        base = rand_index();
        for (int i = 0; i < CAP + 150; i++) begin
            if (i == 100) long_hold_cycles = 250;
            send_word(FUNC_PUSH, base + i, '0, '0, $urandom, $urandom);
        end
        send_word(FUNC_READ, tl_start, 13'(CAP), 12'd0, '0, '0);
        send_word(FUNC_READ, tl_start, 13'(CAP), 12'(CAP - 1), '0, '0);
        send_word(FUNC_READ, tl_start + 1'b1, 13'(CAP), 12'd0, '0, '0);
        send_word(FUNC_READ, tl_start - 1'b1, 13'd2, 12'd0, '0, '0);
        send_word(FUNC_READ, tl_start + (CAP - 1), 13'd1, 12'd0, '0, '0);
        for (int i = 0; i < 30; i++) send_span_read();
        send_word(FUNC_PUSH, tl_start, '0, '0, $urandom, $urandom);
        send_word(FUNC_READ, tl_start, 13'd1, 12'd0, '0, '0);
    endtask

    task automatic test_random_mix();
        int r;
        int s;
        for (int i = 0; i < 800; i++) begin
            if (i % 100 == 0) begin
                tx_gaps_on = ((i / 100) % 3 != 1);
                rx_gaps_on = ((i / 100) % 4 != 2);
            end
            if (i == 400) wait_drained();
            if (i == 600) long_hold_cycles = 300;
            r = $urandom_range(99, 0);
            s = $urandom_range(99, 0);
            if (r < 55) begin
                if (tl_valid && s < 92)
                    send_word(FUNC_PUSH, newest_end_now(), '0, '0, $urandom, $urandom);
                else if (s < 97)
                    send_word(FUNC_PUSH, rand_index(), '0, '0, $urandom, $urandom);
                else
                    send_word(FUNC_PUSH, newest_end_now() + $urandom_range(2, 0) - 1, '0, '0,
                              $urandom, $urandom);
            end else if (r < 95) begin
                if (tl_valid && fill > 0 && s < 80)
                    send_span_read();
                else if (s < 90)
                    send_word(FUNC_READ, tl_start + $urandom_range(24, 0) - 4,
                              LEN_W'($urandom_range(16, 0)), OFF_W'($urandom_range(16, 0)),
                              $urandom, $urandom);
                else
                    send_word(FUNC_READ, rand_index(), LEN_W'($urandom_range(4096, 0)),
                              OFF_W'($urandom), $urandom, $urandom);
            end else if (r < 97) begin
                send_word(FUNC_CLEAR, rand_index(), LEN_W'($urandom_range(4096, 0)),
                          OFF_W'($urandom), $urandom, $urandom);
            end else begin
                send_word(FUNC_NOP, rand_index(), LEN_W'($urandom_range(4096, 0)),
                          OFF_W'($urandom), $urandom, $urandom);
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_ring();
        test_push_and_read_edges();
        test_index_wrap();
        test_full_ring();
        test_random_mix();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
